@@ rtl/abd_pkg.sv @@
package abd_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed field widths
    localparam int COEF_BITS      = 16;
    localparam int LEVEL_BITS     = 15;
    localparam int ENV_BITS       = 15;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_COEFF = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_LEVEL = 2'd2;

    // Register reset values
    localparam logic [COEF_BITS-1:0]  FILTER_GAIN_RST   = 16'd1287;
    localparam logic [COEF_BITS-1:0]  RELEASE_COEFF_RST = 16'd65467;
    localparam logic [LEVEL_BITS-1:0] TRIGGER_LEVEL_RST = 15'd983;

    // Sample queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [COEF_BITS-1:0]  filter_gain;
        logic [COEF_BITS-1:0]  release_coeff;
        logic [LEVEL_BITS-1:0] trigger_level;
    } cfg_t;

endpackage

@@ rtl/abd_front.sv @@
module abd_front #(
    parameter int SAMPLE_BITS = abd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          item_valid,
    input  logic                          item_take,
    output logic signed [SAMPLE_BITS-1:0] item_sample
);
    import abd_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic signed [SAMPLE_BITS-1:0] q_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]           wr_ptr_reg;
    logic [PTR_BITS-1:0]           rd_ptr_reg;
    logic [CNT_BITS-1:0]           count_reg;
    logic                          push;
    logic                          pop;

    assign sample_stall = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign item_valid   = (count_reg != '0);
    assign item_sample  = q_mem[rd_ptr_reg];
    assign push         = sample_valid && !sample_stall;
    assign pop          = item_valid && item_take;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("sample queue count out of range");

endmodule

@@ rtl/abd_back.sv @@
module abd_back #(
    parameter int SAMPLE_BITS = abd_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = abd_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  abd_pkg::cfg_t                 cfg,
    input  logic                          item_valid,
    output logic                          item_take,
    input  logic signed [SAMPLE_BITS-1:0] item_sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          beat_pulse,
    output logic                          beat_active,
    output logic [abd_pkg::ENV_BITS-1:0]  envelope
);
    import abd_pkg::*;

    localparam int W   = SAMPLE_BITS + FRAC_BITS;      // filter stage width
    localparam int PW  = W - 1;                         // envelope width
    localparam int MA  = W + 1;                         // multiplier operand
    localparam int MP  = MA + COEF_BITS + 1;            // product
    localparam int TW  = (PW > LEVEL_BITS + FRAC_BITS) ? PW : LEVEL_BITS + FRAC_BITS;
    localparam int CW  = TW + 4;                        // threshold compare width
    localparam logic [W-1:0] CAP_W =
        ((W'(1) << (SAMPLE_BITS - 1)) - W'(1)) << FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F1,
        ST_F1A,
        ST_F2,
        ST_F2A,
        ST_ABS,
        ST_REL,
        ST_RELA,
        ST_OUT
    } state_t;

    state_t                        state_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [W-1:0]           fs_reg;
    logic signed [W-1:0]           ss_reg;
    logic [PW-1:0]                 e_reg;
    logic [PW-1:0]                 peak_reg;
    logic                          on_reg;
    logic signed [MP-1:0]          prod_reg;
    logic                          result_valid_reg;
    logic                          beat_pulse_reg;
    logic                          beat_active_reg;
    logic [ENV_BITS-1:0]           envelope_reg;

    logic signed [W-1:0]           x_fix;
    logic signed [MA-1:0]          op_a;
    logic [COEF_BITS-1:0]          op_b;
    logic signed [MP-1:0]          prod;
    logic signed [MP-1:0]          prod_sh;
    logic signed [MA-1:0]          incr;
    logic signed [MA-1:0]          fs_sum;
    logic signed [MA-1:0]          ss_sum;
    logic [MA-1:0]                 peak_sum;
    logic [W-1:0]                  mag;
    logic [CW-1:0]                 peak_w;
    logic [CW-1:0]                 peak11;
    logic [CW-1:0]                 thr;
    logic [CW-1:0]                 thr10;
    logic                          on_next;
    logic [PW+ENV_BITS-1:0]        env_ext;
    logic                          out_free;

    assign x_fix = {x_reg, FRAC_BITS'(0)};

    // Operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = cfg.filter_gain;
        unique case (state_reg)
            ST_F1:   op_a = MA'(x_fix) - MA'(fs_reg);
            ST_F2:   op_a = MA'(fs_reg) - MA'(ss_reg);
            ST_REL:
            begin
                op_b = cfg.release_coeff;
                op_a = (e_reg > peak_reg) ? '0
                                          : $signed(MA'(peak_reg) - MA'(e_reg));
            end
            default: op_a = '0;
        endcase
    end

    assign prod     = MP'(op_a) * MP'($signed({1'b0, op_b}));
    assign prod_sh  = prod_reg >>> COEF_BITS;   // floor divide by 2^16
    assign incr     = $signed(prod_sh[MA-1:0]);
    assign fs_sum   = MA'(fs_reg) + incr;
    assign ss_sum   = MA'(ss_reg) + incr;
    assign peak_sum = MA'(e_reg) + incr;
    assign mag      = ss_reg[W-1] ? (~ss_reg + 1'b1) : ss_reg;

    // Schmitt trigger, 11*peak < 10*thr for the off edge
    assign peak_w  = CW'(peak_reg);
    assign peak11  = (peak_w << 3) + (peak_w << 1) + peak_w;
    assign thr     = CW'(cfg.trigger_level) << FRAC_BITS;
    assign thr10   = (thr << 3) + (thr << 1);
    assign on_next = on_reg ? !(peak11 < thr10) : (peak_w > thr);

    assign env_ext  = (PW + ENV_BITS)'(peak_reg) >> FRAC_BITS;
    assign out_free = !result_valid_reg || !result_stall;

    assign item_take    = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign beat_pulse   = beat_pulse_reg;
    assign beat_active  = beat_active_reg;
    assign envelope     = envelope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fs_reg           <= '0;
            ss_reg           <= '0;
            peak_reg         <= '0;
            on_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            x_reg            <= '0;
            e_reg            <= '0;
            prod_reg         <= '0;
            beat_pulse_reg   <= 1'b0;
            beat_active_reg  <= 1'b0;
            envelope_reg     <= '0;
        end
        else
        begin
            // ST_OUT reloads the result register itself
            if (result_valid_reg && !result_stall && state_reg != ST_OUT)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        x_reg     <= item_sample;
                        state_reg <= ST_F1;
                    end
                end
                ST_F1:
                begin
                    prod_reg  <= prod;
                    state_reg <= ST_F1A;
                end
                ST_F1A:
                begin
                    fs_reg    <= fs_sum[W-1:0];
                    state_reg <= ST_F2;
                end
                ST_F2:
                begin
                    prod_reg  <= prod;
                    state_reg <= ST_F2A;
                end
                ST_F2A:
                begin
                    ss_reg    <= ss_sum[W-1:0];
                    state_reg <= ST_ABS;
                end
                ST_ABS:
                begin
                    e_reg     <= (mag > CAP_W) ? CAP_W[PW-1:0] : mag[PW-1:0];
                    state_reg <= ST_REL;
                end
                ST_REL:
                begin
                    prod_reg  <= prod;
                    state_reg <= ST_RELA;
                end
                ST_RELA:
                begin
                    peak_reg  <= peak_sum[PW-1:0];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        on_reg           <= on_next;
                        result_valid_reg <= 1'b1;
                        beat_pulse_reg   <= on_next && !on_reg;
                        beat_active_reg  <= on_next;
                        envelope_reg     <= env_ext[ENV_BITS-1:0];
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (result_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded at end of item");

    a_peak_cap: assert property (@(posedge clk) disable iff (!rst_n)
        W'(peak_reg) <= CAP_W)
        else $error("envelope above magnitude cap");

    a_pulse_active: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!beat_pulse_reg || beat_active_reg))
        else $error("beat pulse without active trigger");

endmodule

@@ rtl/audio_beat_detector.sv @@
// Beat detector for a stream of signed audio samples. Each accepted sample runs
// through two cascaded one-pole low-pass stages (y += g*(x-y), Q0.16 gain), a
// peak envelope with instant attack and exponential release, and a Schmitt
// trigger that turns on above trigger_level and off below trigger_level/1.1.
// Every sample yields exactly one result transfer: beat_pulse on the sample
// where the trigger turns on, beat_active with the trigger state, and the
// integer part of the envelope. A two-entry sample queue sits in front of the
// processing sequencer, so samples are taken while a result waits downstream.
// In the sequencer each sample steps through the two filter updates and the
// release update on one shared multiplier, each product registered before its
// add, and waits in ST_OUT while the result register stays stalled. The user
// must write coefficients through the cfg port only while the block is idle;
// not enforced here; cfg_ready is always high, unused-index writes are dropped.
module audio_beat_detector #(
    parameter int SAMPLE_BITS = abd_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = abd_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample input channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    // result output channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                beat_pulse,
    output logic                                beat_active,
    output logic [abd_pkg::ENV_BITS-1:0]        envelope,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [abd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [abd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import abd_pkg::*;

    cfg_t                          cfg_reg;
    logic                          item_valid;
    logic                          item_take;
    logic signed [SAMPLE_BITS-1:0] item_sample;

    // Registers take any transfer; the user must write them only while idle (unchecked)
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_gain   <= FILTER_GAIN_RST;
            cfg_reg.release_coeff <= RELEASE_COEFF_RST;
            cfg_reg.trigger_level <= TRIGGER_LEVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FILTER_GAIN:   cfg_reg.filter_gain   <= cfg_data[COEF_BITS-1:0];
                REG_RELEASE_COEFF: cfg_reg.release_coeff <= cfg_data[COEF_BITS-1:0];
                REG_TRIGGER_LEVEL: cfg_reg.trigger_level <= cfg_data[LEVEL_BITS-1:0];
                default:           ;  // unused index, write dropped
            endcase
        end
    end

    // Front: takes sample transfers into the queue
    abd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item_sample  (item_sample)
    );

    // Back: filter, envelope and trigger sequencer with result register
    abd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (item_valid),
        .item_take    (item_take),
        .item_sample  (item_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .beat_pulse   (beat_pulse),
        .beat_active  (beat_active),
        .envelope     (envelope)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import abd_pkg::*;

    localparam int  SBITS        = SAMPLE_BITS_DEF;
    localparam int  QBITS        = FRAC_BITS_DEF;
    localparam int  PHASE_ITEMS  = 100;
    localparam int  CYCLE_LIMIT  = 400000;
    // index 3 is not mapped in the block, writes to it must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                pulse;
        logic                active;
        logic [ENV_BITS-1:0] env;
    } beat_result_t;

    // Bit-exact model of the filter / envelope / Schmitt chain plus the queue
    // of results it predicts.
    class beat_predictor;
        longint unsigned gain;
        longint unsigned decay;
        longint unsigned level;
        longint          lp1;
        longint          lp2;
        longint          peak;
        bit              trig;
        bit              trig_prev;
        beat_result_t    pending_q[$];
        int              mismatches;
        int              checked;
        int              beats;

        function new();
            gain       = 64'(FILTER_GAIN_RST);
            decay      = 64'(RELEASE_COEFF_RST);
            level      = 64'(TRIGGER_LEVEL_RST);
            lp1        = 0;
            lp2        = 0;
            peak       = 0;
            trig       = 1'b0;
            trig_prev  = 1'b0;
            mismatches = 0;
            checked    = 0;
            beats      = 0;
        endfunction

        // floor(v * c / 2^16); arithmetic shift rounds toward minus infinity
        function longint mul_q16(longint v, longint unsigned c);
            longint cs;
            cs = longint'(c);
            return (v * cs) >>> 16;
        endfunction

        function void note_config(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_FILTER_GAIN:   gain  = 64'(data);
                REG_RELEASE_COEFF: decay = 64'(data);
                REG_TRIGGER_LEVEL: level = 64'(data[LEVEL_BITS-1:0]);
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SBITS-1:0] s);
            longint       x;
            longint       mag;
            longint       cap;
            longint       thr;
            beat_result_t r;
            x   = longint'(s) * (longint'(1) <<< QBITS);
            lp1 = lp1 + mul_q16(x - lp1, gain);
            lp2 = lp2 + mul_q16(lp1 - lp2, gain);
            mag = (lp2 < 0) ? -lp2 : lp2;
            cap = ((longint'(1) <<< (SBITS - 1)) - 1) * (longint'(1) <<< QBITS);
            if (mag > cap)
                mag = cap;
            if (mag > peak)
                peak = mag;
            else
                peak = mag + mul_q16(peak - mag, decay);
            thr = longint'(level) * (longint'(1) <<< QBITS);
            if (!trig) begin
                if (peak > thr)
                    trig = 1'b1;
            end else if (peak * 11 < thr * 10) begin
                trig = 1'b0;
            end
            r.pulse   = trig && !trig_prev;
            r.active  = trig;
            r.env     = ENV_BITS'(peak >>> QBITS);
            trig_prev = trig;
            pending_q.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH %s", $realtime, msg);
        endfunction

        function void check_result(logic pulse, logic active, logic [ENV_BITS-1:0] env);
            beat_result_t want;
            if (pending_q.size() == 0) begin
                flag($sformatf("unexpected result pulse=%0b active=%0b env=%0d",
                               pulse, active, env));
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (want.pulse)
                beats++;
            if (pulse !== want.pulse || active !== want.active || env !== want.env)
                flag($sformatf("result %0d: exp pulse=%0b active=%0b env=%0d, got pulse=%0b active=%0b env=%0d",
                               checked, want.pulse, want.active, want.env,
                               pulse, active, env));
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        sample_valid;
    logic                        sample_stall;
    logic signed [SBITS-1:0]     sample;
    logic                        result_valid;
    logic                        result_stall;
    logic                        beat_pulse;
    logic                        beat_active;
    logic [ENV_BITS-1:0]         envelope;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    beat_predictor pred;
    int            cycle_count;
    int            samples_sent;
    int            settings_run;
    // sender burst shaping
    int            burst_left;
    bit            gaps_on;
    // receiver stall pattern
    int            stall_mode;
    int            stall_left;

    audio_beat_detector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .beat_pulse   (beat_pulse),
        .beat_active  (beat_active),
        .envelope     (envelope),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Global watchdog; normal runs end far below this.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** audio_beat_detector: FAILED **");
            $finish;
        end
    end

    // Receiver: stall modes change at random run lengths (none, light,
    // heavy, periodic) so result backpressure lands on every sequencer step.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 96);
            end
            stall_left--;
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= ((cycle_count % 5) < 2);
            endcase
        end
    end

    // Result monitor: every accepted transfer is checked against the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            pred.check_result(beat_pulse, beat_active, envelope);
    end

    // One sample transfer; valid stays high until the block takes it.
    task automatic send_sample(input logic signed [SBITS-1:0] s);
        @(negedge clk);
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall);
        pred.note_sample(s);
    endtask

    // Sample with burst/gap shaping on the input side.
    task automatic push_sample(input logic signed [SBITS-1:0] s);
        int gap;
        send_sample(s);
        samples_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                sample_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        pred.note_config(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pred.pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [SBITS-1:0] clip16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return SBITS'(v);
    endfunction

    // Low-frequency square burst with jitter, then a quiet stretch, so the
    // envelope climbs past the trigger and decays back below it.
    task automatic play_tone();
        int hp;
        int periods;
        int amp;
        int jit;
        int v;
        int quiet;
        bit neg;
        hp      = $urandom_range(4, 40);
        periods = $urandom_range(1, 3);
        amp     = $urandom_range(0, 32767);
        jit     = amp / 8 + 1;
        neg     = 1'($urandom_range(0, 1));
        for (int k = 0; k < 2 * periods * hp; k++) begin
            if (k > 0 && (k % hp) == 0)
                neg = !neg;
            v = neg ? -amp : amp;
            v = v + int'($urandom_range(0, 2 * jit)) - jit;
            push_sample(clip16(v));
        end
        quiet = $urandom_range(10, 120);
        for (int k = 0; k < quiet; k++)
            push_sample(clip16(int'($urandom_range(0, 64)) - 32));
    endtask

    initial
    begin
        int         start;
        int         kind;
        int         len;
        logic [15:0] g;
        logic [15:0] r;
        logic [14:0] l;

        clk          = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cycle_count  = 0;
        samples_sent = 0;
        settings_run = 1;
        burst_left   = 4;
        gaps_on      = 1'b1;
        stall_mode   = 0;
        stall_left   = 0;
        pred         = new();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset coefficients: field extremes, alternating bits,
        // then a loud step long enough to push the envelope up.
        push_sample(16'sd0);
        push_sample(16'sd32767);
        push_sample(-16'sd32768);
        push_sample(-16'sd1);
        push_sample(16'sd1);
        push_sample(16'sh5555);
        push_sample(16'shAAAA);
        repeat (8) push_sample(16'sd32767);
        drain_results();

        // Max gain, zero release coefficient, low trigger written with bit 15 set (only
        // the low 15 bits stick), plus a write to the unmapped index.
        write_reg(REG_FILTER_GAIN, 16'hFFFF);
        write_reg(REG_RELEASE_COEFF, 16'h0000);
        write_reg(REG_TRIGGER_LEVEL, 16'h8005);
        write_reg(REG_UNUSED, 16'h1234);
        settings_run++;
        // most negative input drives |second stage| past the cap
        repeat (4) push_sample(-16'sd32768);
        repeat (2) push_sample(16'sd32767);
        // envelope follows e with zero release: trigger drops out
        repeat (3) push_sample(16'sd0);
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin g = 16'hFFFF; r = 16'hFFFF; l = 15'h7FFF; end
                1: begin g = 16'h0000; r = 16'h0000; l = 15'h0000; end
                2: begin
                    g = FILTER_GAIN_RST;
                    r = RELEASE_COEFF_RST;
                    l = TRIGGER_LEVEL_RST;
                end
                3: begin
                    g = 16'($urandom_range(8000, 40000));
                    r = 16'($urandom_range(50000, 65000));
                    l = 15'($urandom_range(500, 8000));
                end
                4: begin
                    g = 16'($urandom);
                    r = 16'($urandom);
                    l = 15'($urandom);
                end
                default: begin
                    g = 16'($urandom_range(15000, 25000));
                    r = 16'($urandom_range(58000, 62000));
                    l = 15'($urandom_range(2000, 12000));
                end
            endcase
            write_reg(REG_FILTER_GAIN, g);
            write_reg(REG_RELEASE_COEFF, r);
            write_reg(REG_TRIGGER_LEVEL, {1'($urandom), l});
            if ($urandom_range(0, 1))
                write_reg(REG_UNUSED, 16'($urandom));
            settings_run++;
            // one phase runs the sender back to back
            gaps_on = (ph != 3);

            start = samples_sent;
            while (samples_sent - start < PHASE_ITEMS) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    len = $urandom_range(1, 20);
                    repeat (len) push_sample(SBITS'($urandom));
                end else if (kind == 1) begin
                    case ($urandom_range(0, 2))
                        0: push_sample(-16'sd32768);
                        1: push_sample(16'sd32767);
                        default: push_sample(16'sd0);
                    endcase
                end else begin
                    play_tone();
                end
            end
            drain_results();
        end

        // nothing should trickle out once the queue is empty
        repeat (40) @(posedge clk);

        $display("Sent %0d samples under %0d coefficient settings.",
                 samples_sent, settings_run);
        $display("Checked %0d results, %0d beat pulses, %0d mismatches.",
                 pred.checked, pred.beats, pred.mismatches);
        if (pred.mismatches == 0 && pred.pending_q.size() == 0)
            $display("** audio_beat_detector: PASSED **");
        else
            $display("** audio_beat_detector: FAILED **");
        $finish;
    end

endmodule

@@ audio_beat_detector.f @@
rtl/abd_pkg.sv
rtl/abd_front.sv
rtl/abd_back.sv
rtl/audio_beat_detector.sv
tb/tb.sv
